### design/integer_to_roman_numeral_defines.svh
// Assertion macros shared by the integer to Roman numeral block
`ifndef INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define ITRN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ITRN_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### design/itrn_pkg.sv
// Package: widths, letter codes, control word types and the microprogram table
package itrn_pkg;

	localparam int NUM_W    = 12;
	localparam int LET_W    = 7;
	localparam int STEP_W   = 5;
	localparam int PROG_LEN = 19;

	typedef logic [NUM_W-1:0]  num_t;
	typedef logic [LET_W-1:0]  let_t;
	typedef logic [STEP_W-1:0] step_t;

	// ASCII letter codes
	localparam let_t LET_I = 7'd73;
	localparam let_t LET_V = 7'd86;
	localparam let_t LET_X = 7'd88;
	localparam let_t LET_L = 7'd76;
	localparam let_t LET_C = 7'd67;
	localparam let_t LET_D = 7'd68;
	localparam let_t LET_M = 7'd77;

	// Microprogram step addresses
	localparam step_t S_M     = 5'd0;
	localparam step_t S_CM_C  = 5'd1;
	localparam step_t S_CM_M  = 5'd2;
	localparam step_t S_D     = 5'd3;
	localparam step_t S_CD_C  = 5'd4;
	localparam step_t S_CD_D  = 5'd5;
	localparam step_t S_C     = 5'd6;
	localparam step_t S_XC_X  = 5'd7;
	localparam step_t S_XC_C  = 5'd8;
	localparam step_t S_L     = 5'd9;
	localparam step_t S_XL_X  = 5'd10;
	localparam step_t S_XL_L  = 5'd11;
	localparam step_t S_X     = 5'd12;
	localparam step_t S_IX_I  = 5'd13;
	localparam step_t S_IX_X  = 5'd14;
	localparam step_t S_V     = 5'd15;
	localparam step_t S_IV_I  = 5'd16;
	localparam step_t S_IV_V  = 5'd17;
	localparam step_t S_I     = 5'd18;

	// One control word: emit letter when remainder >= thr, then subtract sub
	typedef struct packed {
		num_t  thr;
		num_t  sub;
		let_t  letter;
		step_t nxt_take;
		step_t nxt_skip;
	} uword_t;

	// Sequencer to datapath and output stage
	typedef struct packed {
		logic  load;
		logic  emit;
		num_t  thr;
		num_t  sub;
		let_t  letter;
	} ctl_t;

	// Datapath status back to the sequencer
	typedef struct packed {
		logic take;
		logic last;
	} sts_t;

	function automatic uword_t mk(input int thr, input int sub, input let_t letter,
			input step_t nt, input step_t ns);
		uword_t w;
		w.thr      = NUM_W'(thr);
		w.sub      = NUM_W'(sub);
		w.letter   = letter;
		w.nxt_take = nt;
		w.nxt_skip = ns;
		return w;
	endfunction

	// Microprogram: greedy walk over 1000, 900, ... 4, 1
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		case (step)
			S_M:     w = mk(1000, 1000, LET_M, S_M,    S_CM_C);
			S_CM_C:  w = mk(900,  0,    LET_C, S_CM_M, S_D);
			S_CM_M:  w = mk(0,    900,  LET_M, S_XC_X, S_XC_X);
			S_D:     w = mk(500,  500,  LET_D, S_C,    S_CD_C);
			S_CD_C:  w = mk(400,  0,    LET_C, S_CD_D, S_C);
			S_CD_D:  w = mk(0,    400,  LET_D, S_XC_X, S_XC_X);
			S_C:     w = mk(100,  100,  LET_C, S_C,    S_XC_X);
			S_XC_X:  w = mk(90,   0,    LET_X, S_XC_C, S_L);
			S_XC_C:  w = mk(0,    90,   LET_C, S_IX_I, S_IX_I);
			S_L:     w = mk(50,   50,   LET_L, S_X,    S_XL_X);
			S_XL_X:  w = mk(40,   0,    LET_X, S_XL_L, S_X);
			S_XL_L:  w = mk(0,    40,   LET_L, S_IX_I, S_IX_I);
			S_X:     w = mk(10,   10,   LET_X, S_X,    S_IX_I);
			S_IX_I:  w = mk(9,    0,    LET_I, S_IX_X, S_V);
			S_IX_X:  w = mk(0,    9,    LET_X, S_M,    S_M);
			S_V:     w = mk(5,    5,    LET_V, S_I,    S_IV_I);
			S_IV_I:  w = mk(4,    0,    LET_I, S_IV_V, S_I);
			S_IV_V:  w = mk(0,    4,    LET_V, S_M,    S_M);
			S_I:     w = mk(1,    1,    LET_I, S_I,    S_M);
			default: w = mk(0,    0,    LET_I, S_M,    S_M);
		endcase
		return w;
	endfunction

endpackage

### design/itrn_dp.sv
// Datapath: remainder register, threshold compare and subtract
module itrn_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  itrn_pkg::num_t number,
	input  itrn_pkg::ctl_t ctl,
	output itrn_pkg::sts_t sts
);
	import itrn_pkg::*;

	num_t rem_q;
	num_t rem_nxt;

	// Compare against the step threshold and form the reduced remainder
	assign rem_nxt  = rem_q - ctl.sub;
	assign sts.take = (rem_q >= ctl.thr);
	assign sts.last = (rem_nxt == '0);

	// Load a new number, reduce on every emitted letter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctl.load) begin
			rem_q <= number;
		end else if (ctl.emit) begin
			rem_q <= rem_nxt;
		end
	end

endmodule

### design/itrn_useq.sv
// Sequencer: step counter, microprogram lookup and conditional jumps
`include "integer_to_roman_numeral_defines.svh"

module itrn_useq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  itrn_pkg::num_t number,
	input  logic          out_free,
	input  itrn_pkg::sts_t sts,
	output logic          busy,
	output itrn_pkg::ctl_t ctl
);
	import itrn_pkg::*;

	logic   busy_q;
	step_t  step_q;
	uword_t word;
	logic   advance;

	// Fetch the control word of the current step
	assign word = ucode(step_q);

	// Start on a nonzero number; zero has an empty numeral
	assign ctl.load   = in_valid && !busy_q && (number != '0);
	assign ctl.emit   = busy_q && sts.take && out_free;
	assign ctl.thr    = word.thr;
	assign ctl.sub    = word.sub;
	assign ctl.letter = word.letter;
	assign busy       = busy_q;

	// Hold a taken step until the output slot frees
	assign advance = busy_q && (!sts.take || out_free);

	// Advance the step counter and jump on the compare result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= S_M;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			step_q <= S_M;
		end else if (advance) begin
			if (sts.take) begin
				step_q <= word.nxt_take;
				if (sts.last) begin
					busy_q <= 1'b0;
				end
			end else begin
				step_q <= word.nxt_skip;
			end
		end
	end

	`ITRN_ASSERT(a_step_range, step_q < STEP_W'(PROG_LEN), "step counter left the program")
	`ITRN_ASSERT(a_emit_free, ctl.emit |-> out_free, "letter emitted into a full slot")
	`ITRN_ASSERT(a_load_busy, ctl.load |=> busy_q, "sequencer did not start on load")
	`ITRN_ASSERT(a_last_done, (ctl.emit && sts.last) |=> !busy_q, "run kept going past last")
	`ITRN_NEVER(a_emit_idle, ctl.emit && !busy_q, "letter emitted while idle")

endmodule

### design/integer_to_roman_numeral.sv
// Top level: integer to Roman numeral converter, one letter beat per emitting microprogram step.
// Before its first letter a number walks through the compare steps whose threshold it does
// not reach; those steps emit nothing.
// The single-step sequencer runs one step per cycle, save that a taken step waits for a free
// output slot; the input stays stalled while a number runs its steps. A zero starts no run.
// Reset idles sequencer and output register.
module integer_to_roman_numeral (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [itrn_pkg::NUM_W-1:0] number,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [itrn_pkg::LET_W-1:0] letter,
	output logic                      last_letter
);
	import itrn_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic busy;
	logic out_free;
	logic out_valid_q;
	let_t letter_q;
	logic last_q;

	// Output slot is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = busy;

	itrn_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.number   (number),
		.out_free (out_free),
		.sts      (sts),
		.busy     (busy),
		.ctl      (ctl)
	);

	itrn_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number),
		.ctl    (ctl),
		.sts    (sts)
	);

	// Hold the output beat until taken, load a new letter on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			letter_q <= ctl.letter;
			last_q   <= sts.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign letter      = letter_q;
	assign last_letter = last_q;

endmodule

### dv/tb.sv
// Testbench for the integer to Roman numeral converter: queued driver, checking monitor
`timescale 1ns / 100ps

module tb;
	import itrn_pkg::*;

	localparam int MAX_LETTERS = 15;
	localparam int IDLE_PCT    = 38;
	localparam int HOLD_AT     = 60;
	localparam int HOLD_LEN    = 150;
	localparam int QUIET_FROM  = 120;
	localparam int QUIET_TO    = 170;
	localparam int RANDOM_NUMS = 200;
	localparam int DRAIN_CYC   = 40;

	// One expected output beat
	typedef struct packed {
		let_t letter;
		logic last;
	} glyph_t;

	logic clk;
	logic arst_n      = 1'b0;
	logic in_valid    = 1'b0;
	logic in_stall;
	num_t number      = '0;
	logic out_valid;
	logic out_stall   = 1'b0;
	let_t letter;
	logic last_letter;

	num_t   pending_q[$];
	glyph_t numeral_q[$];
	glyph_t spell_q[$];
	int     sent_cnt  = 0;
	int     hold_cnt  = 0;
	int     errors    = 0;

	integer_to_roman_numeral i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.number      (number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.letter      (letter),
		.last_letter (last_letter)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random idle decision, suppressed inside the quiet window
	function automatic bit roll_idle();
		if (sent_cnt >= QUIET_FROM && sent_cnt < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	// Append one letter to the numeral under construction, capped at the longest run
	task automatic put_glyph(input let_t c);
		glyph_t g;
		g.letter = c;
		g.last   = 1'b0;
		if (spell_q.size() < MAX_LETTERS)
			spell_q.push_back(g);
	endtask

	// Spell a number in Roman letters and queue the letters as expected beats
	task automatic spell_number(input num_t n);
		int   val;
		int   d;
		int   div;
		let_t one;
		let_t five;
		let_t ten;
		glyph_t g;
		val = n;
		spell_q.delete();
		// thousands: plain repeated M, even past three
		repeat (val / 1000) put_glyph(LET_M);
		for (int place = 2; place >= 0; place--) begin
			case (place)
				2: begin div = 100; one = LET_C; five = LET_D; ten = LET_M; end
				1: begin div = 10;  one = LET_X; five = LET_L; ten = LET_C; end
				default: begin div = 1; one = LET_I; five = LET_V; ten = LET_X; end
			endcase
			d = (val / div) % 10;
			if (d == 9) begin
				put_glyph(one);
				put_glyph(ten);
			end else if (d == 4) begin
				put_glyph(one);
				put_glyph(five);
			end else begin
				if (d >= 5) begin
					put_glyph(five);
					d = d - 5;
				end
				repeat (d) put_glyph(one);
			end
		end
		// zero spells nothing, so nothing is expected
		while (spell_q.size() > 0) begin
			g = spell_q.pop_front();
			g.last = (spell_q.size() == 0);
			numeral_q.push_back(g);
		end
	endtask

	// Driver: record accepted beats, then offer the next pending number or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			number   <= '0;
			sent_cnt <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				spell_number(number);
				sent_cnt <= sent_cnt + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_q.size() > 0 && !roll_idle()) begin
					number   <= pending_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted letter, then choose the next stall
	always @(posedge clk or negedge arst_n) begin
		glyph_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cnt  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (numeral_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual letter %0d last %0b",
						$time, letter, last_letter);
					errors++;
				end else begin
					want = numeral_q.pop_front();
					if (letter !== want.letter) begin
						$display("%0t: letter mismatch, expected %0d, actual %0d",
							$time, want.letter, letter);
						errors++;
					end
					if (last_letter !== want.last) begin
						$display("%0t: last_letter mismatch, expected %0b, actual %0b",
							$time, want.last, last_letter);
						errors++;
					end
				end
			end
			// hold off once for a long stretch so the block backs up into its input
			if (sent_cnt >= HOLD_AT && hold_cnt < HOLD_LEN) begin
				hold_cnt  <= hold_cnt + 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= roll_idle();
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int pick;
		// directed: every digit form, both ends of the range, zero and above range
		pending_q = '{1, 2, 3, 4, 5, 8, 9, 10, 40, 49, 50, 90, 99, 100, 400, 444,
			500, 900, 999, 1000, 3888, 3999, 0, 4000, 4095};
		for (int i = 0; i < RANDOM_NUMS; i++) begin
			pick = $urandom_range(99);
			if (pick < 6)
				pending_q.push_back(num_t'(0));
			else if (pick < 12)
				pending_q.push_back(num_t'($urandom_range(4095, 4000)));
			else
				pending_q.push_back(num_t'($urandom_range(3999, 1)));
		end
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// drain: all numbers accepted and every expected letter seen
		while (pending_q.size() != 0 || in_valid || numeral_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
		if (errors == 0 && numeral_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

### integer_to_roman_numeral.f
+incdir+design
design/itrn_pkg.sv
design/itrn_dp.sv
design/itrn_useq.sv
design/integer_to_roman_numeral.sv
dv/tb.sv
